FILE: design/multiset_permutation_generator_top_macros.svh
// ----------------------------------------------------------------------------
// multiset permutation generator assertion macros
// shared assertion forms for the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef MULTISET_PERMUTATION_GENERATOR_TOP_MACROS_SVH
`define MULTISET_PERMUTATION_GENERATOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mpg_pkg.sv
// ----------------------------------------------------------------------------
// mpg_pkg
// types, codes and defaults for the multiset permutation generator
// ----------------------------------------------------------------------------
package mpg_pkg;

    // default capacity of the multiset
    localparam int MaxElemsDef = 8;

    // fixed field widths
    localparam int ElemW = 32;
    localparam int PosW  = 3;

    // opcode values
    localparam logic OpLoad = 1'b0;
    localparam logic OpNext = 1'b1;

    // input word
    typedef struct packed {
        logic                    opcode;
        logic signed [ElemW-1:0] value;
        logic                    set_end;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [ElemW-1:0] element;
        logic [PosW-1:0]         position;
        logic                    perm_end;
        logic                    done_res;
    } t_out_word;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic walk_step;
        logic restore;
        logic emit_start;
        logic emit_word;
        logic done_word;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic walk_ok;
        logic out_free;
        logic exhaust;
        logic back;
        logic take_last;
        logic emit_last;
    } t_sts;

endpackage

FILE: design/mpg_ctrl.sv
// ----------------------------------------------------------------------------
// mpg_ctrl
// sequencer for loads, backtracking steps and word emission
// ----------------------------------------------------------------------------
`include "multiset_permutation_generator_top_macros.svh"

module mpg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_opcode,
    output logic          o_in_stall,
    input  mpg_pkg::t_sts i_sts,
    output mpg_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SEARCH  = 5'b00010,
        S_RESTORE = 5'b00100,
        S_EMIT    = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // one item at a time
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == mpg_pkg::OpLoad) begin
                        o_cmd.load = 1'b1;
                    end else if (i_sts.walk_ok) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.exhaust) begin
                    n_state = S_DONE;
                end else if (i_sts.back) begin
                    n_state = S_RESTORE;
                end else if (i_sts.take_last) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT;
                end
            end
            S_RESTORE: begin
                o_cmd.restore = 1'b1;
                n_state       = S_SEARCH;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_word = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.done_word = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a request always produces at least one word before idling
    `MPG_ASSERT_NEXT(a_request_leaves_idle, i_clk, i_rst_n, accept && (i_opcode == mpg_pkg::OpNext), r_state != S_IDLE, "request did not start work")
    // words go out only when the output register can take them
    `MPG_ASSERT_NOW(a_push_needs_room, i_clk, i_rst_n, o_cmd.emit_word || o_cmd.done_word, i_sts.out_free, "word pushed into a full output register")
    // the last element ends the permutation
    `MPG_ASSERT_NEXT(a_emit_last_to_idle, i_clk, i_rst_n, (r_state == S_EMIT) && i_sts.out_free && i_sts.emit_last, r_state == S_IDLE, "emission did not finish after last element")

endmodule

FILE: design/mpg_datapath.sv
// ----------------------------------------------------------------------------
// mpg_datapath
// symbol tables, backtracking state and output register
// ----------------------------------------------------------------------------
`include "multiset_permutation_generator_top_macros.svh"

module mpg_datapath #(
    parameter int MAX_ELEMS = mpg_pkg::MaxElemsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpg_pkg::t_in_word  i_word,
    input  mpg_pkg::t_cmd      i_cmd,
    output mpg_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output mpg_pkg::t_out_word o_out_word
);

    localparam int IdxW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CntW = $clog2(MAX_ELEMS + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ELEMS);

    // stores
    logic signed [mpg_pkg::ElemW-1:0] r_table [MAX_ELEMS];
    logic [CntW-1:0]                  r_count [MAX_ELEMS];
    logic [CntW-1:0]                  r_choice [MAX_ELEMS];
    logic signed [mpg_pkg::ElemW-1:0] r_perm [MAX_ELEMS];

    // walk and set state
    logic [IdxW-1:0]    r_level;
    logic [CntW-1:0]    r_elem_total;
    logic [CntW-1:0]    r_distinct;
    logic               r_closed;
    logic               r_exhausted;
    logic [IdxW-1:0]    r_emit_idx;
    logic               r_out_valid;
    mpg_pkg::t_out_word r_out;

    // combinational helpers
    logic [CntW-1:0]      choice;
    logic [IdxW-1:0]      choice_idx;
    logic                 choice_live;
    logic [CntW-1:0]      lvl_ext;
    logic                 level_ok;
    logic                 take;
    logic                 take_last;
    logic [CntW-1:0]      eff_total;
    logic [CntW-1:0]      eff_distinct;
    logic                 room;
    logic [MAX_ELEMS-1:0] hit;
    logic                 any_hit;
    logic [IdxW-1:0]      hit_idx;
    logic [IdxW-1:0]      new_idx;
    logic [IdxW-1:0]      rd_addr;
    logic [CntW-1:0]      rd_cnt;
    logic                 cnt_we;
    logic [IdxW-1:0]      cnt_waddr;
    logic [CntW-1:0]      cnt_wdata;
    logic                 emit_last;
    logic                 out_free;

    // symbol under trial at the current level
    assign choice      = r_choice[r_level];
    assign choice_idx  = choice[IdxW-1:0];
    assign choice_live = (choice < r_distinct);
    assign lvl_ext     = CntW'(r_level);
    assign level_ok    = (lvl_ext < r_elem_total);

    // a closed set starts over on the next load
    assign eff_total    = r_closed ? '0 : r_elem_total;
    assign eff_distinct = r_closed ? '0 : r_distinct;
    assign room         = (eff_total < MaxCnt);
    assign new_idx      = eff_distinct[IdxW-1:0];

    // match against known symbols
    always_comb begin
        for (int j = 0; j < MAX_ELEMS; j++) begin
            hit[j] = (CntW'(j) < eff_distinct) && (r_table[j] == i_word.value);
        end
    end

    always_comb begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int j = MAX_ELEMS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_idx = IdxW'(j);
                any_hit = 1'b1;
            end
        end
    end

    // single count read port
    assign rd_addr = i_cmd.load ? hit_idx : choice_idx;
    assign rd_cnt  = r_count[rd_addr];

    // classify the walk step
    assign take      = level_ok && choice_live && (rd_cnt != '0);
    assign take_last = take && ((lvl_ext + CntW'(1)) == r_elem_total);

    assign emit_last = ((CntW'(r_emit_idx) + CntW'(1)) == r_elem_total);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts           = '0;
        o_sts.walk_ok   = r_closed && (r_elem_total != '0) && !r_exhausted;
        o_sts.out_free  = out_free;
        o_sts.exhaust   = !level_ok || (!choice_live && (r_level == '0));
        o_sts.back      = level_ok && !choice_live && (r_level != '0);
        o_sts.take_last = take_last;
        o_sts.emit_last = emit_last;
    end

    // count write port
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = choice_idx;
        cnt_wdata = rd_cnt + CntW'(1);
        if (i_cmd.load && room) begin
            cnt_we = 1'b1;
            if (any_hit) begin
                cnt_waddr = hit_idx;
            end else begin
                cnt_waddr = new_idx;
                cnt_wdata = CntW'(1);
            end
        end else if (i_cmd.walk_step && take && !take_last) begin
            cnt_we    = 1'b1;
            cnt_wdata = rd_cnt - CntW'(1);
        end else if (i_cmd.restore) begin
            cnt_we = 1'b1;
        end
    end

    // table, count and permutation stores
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_count[cnt_waddr] <= cnt_wdata;
        end
        if (i_cmd.load && room && !any_hit) begin
            r_table[new_idx] <= i_word.value;
        end
        if (i_cmd.walk_step && take) begin
            r_perm[r_level] <= r_table[choice_idx];
        end
    end

    // walk state, set bookkeeping and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_elem_total <= '0;
            r_distinct   <= '0;
            r_closed     <= 1'b0;
            r_exhausted  <= 1'b0;
            r_emit_idx   <= '0;
            r_out_valid  <= 1'b0;
            for (int j = 0; j < MAX_ELEMS; j++) begin
                r_choice[j] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_elem_total <= room ? (eff_total + CntW'(1)) : eff_total;
                r_distinct   <= (room && !any_hit) ? (eff_distinct + CntW'(1)) : eff_distinct;
                r_closed     <= i_word.set_end;
                r_exhausted  <= 1'b0;
                if (r_closed || i_word.set_end) begin
                    r_level <= '0;
                    for (int j = 0; j < MAX_ELEMS; j++) begin
                        r_choice[j] <= '0;
                    end
                end
            end
            if (i_cmd.walk_step) begin
                if (o_sts.exhaust) begin
                    r_exhausted <= 1'b1;
                    r_level     <= '0;
                end else if (o_sts.back) begin
                    r_choice[r_level] <= '0;
                    r_level           <= r_level - IdxW'(1);
                end else if (take && !take_last) begin
                    r_level <= r_level + IdxW'(1);
                end else begin
                    // skip an empty symbol, or step past the one just completed
                    r_choice[r_level] <= choice + CntW'(1);
                end
            end
            if (i_cmd.restore) begin
                r_choice[r_level] <= choice + CntW'(1);
            end
            if (i_cmd.emit_start) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_word) begin
                r_emit_idx <= r_emit_idx + IdxW'(1);
            end
            if (i_cmd.emit_word || i_cmd.done_word) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_word) begin
            r_out.element  <= r_perm[r_emit_idx];
            r_out.position <= mpg_pkg::PosW'(r_emit_idx);
            r_out.perm_end <= emit_last;
            r_out.done_res <= 1'b0;
        end else if (i_cmd.done_word) begin
            r_out.element  <= '0;
            r_out.position <= '0;
            r_out.perm_end <= 1'b1;
            r_out.done_res <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // symbol grouping never outgrows the element count
    `MPG_ASSERT_NOW(a_distinct_le_total, i_clk, i_rst_n, 1'b1, r_distinct <= r_elem_total, "more symbols than elements")
    // the walk depth stays inside a closed set
    `MPG_ASSERT_NOW(a_level_in_range, i_clk, i_rst_n, r_closed && (r_elem_total != '0), lvl_ext < r_elem_total, "walk level beyond element count")
    // a done word lands in the output register with its markers
    `MPG_ASSERT_NEXT(a_done_word_out, i_clk, i_rst_n, i_cmd.done_word, r_out_valid && r_out.done_res && r_out.perm_end, "done word not presented")

endmodule

FILE: design/multiset_permutation_generator_top.sv
// a load leaves the input unstalled and the next word may follow in the next cycle
// a request walks a search step per symbol taken or skipped and a restore
// step per backtrack, then loads its n elements into the output register
// one per free cycle; a refused request loads its done word when there is room
// input stalls from a request until its last word is in the output register
// reset clears the set (empty, open), the walk and the output valid
// ----------------------------------------------------------------------------
// multiset_permutation_generator_top
// loads a multiset and emits its distinct permutations on request
// ----------------------------------------------------------------------------
module multiset_permutation_generator_top #(
    parameter int MAX_ELEMS = mpg_pkg::MaxElemsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mpg_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mpg_pkg::t_out_word o_out_word
);

    mpg_pkg::t_cmd cmd;
    mpg_pkg::t_sts sts;

    // sequencer
    mpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_word.opcode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and walk datapath
    mpg_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: dv/tb_multiset_permutation_generator_top.sv
// ----------------------------------------------------------------------------
// tb_multiset_permutation_generator_top
// checks the multiset permutation generator against its own walk predictor:
// directed sets for the edge cases, then random sets with duplicates, broken
// loads and exhausting request runs, under random sender gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_multiset_permutation_generator_top;
    import mpg_pkg::*;

    // predictor of the enumeration and store of the words still to come
    class perm_tracker;
        logic [ElemW-1:0] sym_val [MaxElemsDef];
        int               sym_cnt [MaxElemsDef];
        int               choice  [MaxElemsDef];
        logic [ElemW-1:0] built   [MaxElemsDef];
        int               depth;
        int               n_loaded;
        int               n_distinct;
        bit               closed;
        bit               spent;
        t_out_word        pending_elems [$];
        int               errors;

        function new();
            clear_set();
            errors = 0;
        endfunction

        function void clear_set();
            foreach (sym_val[i]) begin
                sym_val[i] = '0;
                sym_cnt[i] = 0;
                choice[i]  = 0;
                built[i]   = '0;
            end
            depth      = 0;
            n_loaded   = 0;
            n_distinct = 0;
            closed     = 1'b0;
            spent      = 1'b0;
        endfunction

        // append one expected word at the tail
        function void enqueue_word(t_out_word w);
            pending_elems = {pending_elems, w};
        endfunction

        function void push_done();
            t_out_word w;
            w          = '0;
            w.perm_end = 1'b1;
            w.done_res = 1'b1;
            enqueue_word(w);
        endfunction

        // group the value into its symbol, values past capacity are dropped
        function void load_value(logic [ElemW-1:0] v, logic last);
            int j;
            if (closed) clear_set();
            if (n_loaded < MaxElemsDef) begin
                j = 0;
                while (j < n_distinct && sym_val[j] != v) j++;
                if (j < n_distinct) begin
                    sym_cnt[j]++;
                end else begin
                    sym_val[j] = v;
                    sym_cnt[j] = 1;
                    n_distinct++;
                end
                n_loaded++;
            end
            if (last) begin
                closed = 1'b1;
                spent  = 1'b0;
                foreach (choice[i]) choice[i] = 0;
                depth  = 0;
            end
        endfunction

        // resume the backtracking walk up to the next full permutation
        function void walk_next();
            int n;
            int k;
            int d;
            t_out_word w;
            n = n_loaded;
            k = n_distinct;
            d = depth;
            if (!closed || n == 0 || spent) begin
                push_done();
                return;
            end
            while (1) begin
                if (d >= MaxElemsDef || d >= n) begin
                    spent = 1'b1;
                    push_done();
                    return;
                end
                while (choice[d] < k && sym_cnt[choice[d]] == 0) choice[d]++;
                if (choice[0] >= k) begin
                    spent = 1'b1;
                    depth = 0;
                    push_done();
                    return;
                end
                if (choice[d] >= k) begin
                    choice[d] = 0;
                    d--;
                    sym_cnt[choice[d]]++;
                    choice[d]++;
                    continue;
                end
                built[d] = sym_val[choice[d]];
                sym_cnt[choice[d]]--;
                d++;
                if (d == n) begin
                    for (int i = 0; i < n; i++) begin
                        w          = '0;
                        w.element  = built[i];
                        w.position = i[PosW-1:0];
                        w.perm_end = (i + 1 == n);
                        enqueue_word(w);
                    end
                    d--;
                    sym_cnt[choice[d]]++;
                    choice[d]++;
                    depth = d;
                    return;
                end
            end
        endfunction

        function void note_word(t_in_word w);
            if (w.opcode == OpLoad) load_value(w.value, w.set_end);
            else walk_next();
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (pending_elems.size() == 0) begin
                $error("unexpected output word: element %0d position %0d done %0d",
                       got.element, got.position, got.done_res);
                errors++;
                return;
            end
            want = pending_elems.pop_front();
            if (got.element !== want.element) begin
                $error("element: expected %0d, got %0d", want.element, got.element);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.perm_end !== want.perm_end) begin
                $error("perm_end: expected %0d, got %0d", want.perm_end, got.perm_end);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_elems.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;

    perm_tracker board;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          hold_ask   = 1'b0;

    multiset_permutation_generator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender pacing: bursts of random length, random gaps, some long runs
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // offer one word and hold it until the block takes it
    task automatic send_word(t_in_word w);
        pace();
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        board.note_word(w);
        items_sent++;
    endtask

    task automatic send_load(logic [ElemW-1:0] v, logic last);
        t_in_word w;
        w.opcode  = OpLoad;
        w.value   = v;
        w.set_end = last;
        send_word(w);
    endtask

    // request with random filler in the unused fields
    task automatic send_request();
        t_in_word w;
        w.opcode  = OpNext;
        w.value   = $urandom;
        w.set_end = 1'($urandom_range(0, 1));
        send_word(w);
    endtask

    function automatic logic [ElemW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // edge cases: empty and open sets, duplicates, exhaustion, reload, overflow
    task automatic run_directed();
        send_request();
        send_load(32'h7fff_ffff, 1'b0);
        send_request();
        send_load(32'h8000_0000, 1'b0);
        send_load(32'h7fff_ffff, 1'b1);
        repeat (5) send_request();
        send_load(32'hffff_ffff, 1'b1);
        repeat (2) send_request();
        repeat (8) send_load(32'h0000_0000, 1'b0);
        send_load(32'h0000_0005, 1'b1);
        repeat (2) send_request();
    endtask

    // random sets, mostly well formed, some broken by requests or missing ends
    task automatic run_random(int n_items);
        int               r;
        int               n;
        int               pool_n;
        int               reqs;
        logic [ElemW-1:0] pool [3];
        logic [ElemW-1:0] v;
        int               stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (items_sent > 60) hold_ask = 1'b1;
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_request();
            end else if (r == 1) begin
                repeat ($urandom_range(1, 3)) send_load(pick_value(), 1'b0);
            end else begin
                r = $urandom_range(0, 9);
                n = (r < 6) ? $urandom_range(1, 4) :
                    (r < 9) ? $urandom_range(5, 8) : $urandom_range(9, 11);
                pool_n = $urandom_range(1, 4);
                foreach (pool[i]) pool[i] = pick_value();
                for (int i = 0; i < n; i++) begin
                    v = (pool_n == 4) ? pick_value() : pool[$urandom_range(0, pool_n - 1)];
                    if ($urandom_range(0, 29) == 0) send_request();
                    send_load(v, i == n - 1);
                end
                reqs = (n <= 4 && $urandom_range(0, 2) == 0) ? 26 : $urandom_range(1, 6);
                repeat (reqs) send_request();
            end
        end
    endtask

    // output sink: own stall pattern, one long hold-off to back the block up
    initial begin
        int  mode;
        int  len;
        bit  held;
        held = 1'b0;
        i_out_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_ask && !held) begin
                held = 1'b1;
                repeat (400) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(5, 60);
                for (int k = 0; k < len; k++) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= 1'($urandom_range(0, 1));
                        2:       i_out_stall <= (k % 3 == 0);
                        default: i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_word(o_out_word);
    end

    // main sequence
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        board      = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(300);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/mpg_pkg.sv
design/mpg_ctrl.sv
design/mpg_datapath.sv
design/multiset_permutation_generator_top.sv
dv/tb_multiset_permutation_generator_top.sv
